// ===== hdl/fpsc_pkg.sv =====
// Shared types, widths and polynomial constants for the fixed-point sine/cosine block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.

package fpsc_pkg;

    // Fraction bits of angle, sine and cosine
    localparam int SHIFT    = 24;
    localparam int TAB_BITS = 30;

    localparam int ANGLE_W = 28;
    localparam int OUT_W   = 26;
    localparam int FOLD_W  = ANGLE_W + 1;
    localparam int X2_W    = 30;
    localparam int ACC_W   = 32;
    localparam int NCELL   = 5;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [FOLD_W-1:0]  fold_t;
    typedef logic signed [X2_W-1:0]    x2_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [OUT_W-1:0]   out_t;

    // Data that travels down the cell chain next to the Horner sums
    typedef struct packed {
        x2_t    x2;
        angle_t t;
        logic   folded;
    } carry_t;

    // floor(pi * 2^30)
    localparam longint unsigned PI_AT_30 = 64'h0000_0000_C90F_DAA2;

    localparam fold_t PI_FX      = FOLD_W'(PI_AT_30 >> (TAB_BITS - SHIFT));
    localparam fold_t HPI_FX     = FOLD_W'(PI_AT_30 >> (TAB_BITS + 1 - SHIFT));
    localparam fold_t NEG_PI_FX  = -PI_FX;
    localparam fold_t NEG_HPI_FX = -HPI_FX;

    // Coefficient magnitudes floor(|c| * 2^(s+30))
    localparam logic [31:0] MS1  = 32'd1073741805;
    localparam logic [31:0] MS3  = 32'd715827232;
    localparam logic [31:0] MS5  = 32'd572636926;
    localparam logic [31:0] MS7  = 32'd871022349;
    localparam logic [31:0] MS9  = 32'd731303076;
    localparam logic [31:0] MC0  = 32'd1073741823;
    localparam logic [31:0] MC2  = 32'd1073741813;
    localparam logic [31:0] MC4  = 32'd715827456;
    localparam logic [31:0] MC6  = 32'd763524649;
    localparam logic [31:0] MC8  = 32'd871297840;
    localparam logic [31:0] MC10 = 32'd588059552;

    // Drop the table's extra fraction bits, then apply the sign
    function automatic acc_t coef(input logic [31:0] mag, input logic neg);
        acc_t m;
        m = ACC_W'(mag >> (TAB_BITS - SHIFT));
        return neg ? -m : m;
    endfunction

    localparam acc_t ACC_ZERO = '0;

    localparam acc_t K_S1  = coef(MS1, 1'b0);
    localparam acc_t K_S3  = coef(MS3, 1'b1);
    localparam acc_t K_S5  = coef(MS5, 1'b0);
    localparam acc_t K_S7  = coef(MS7, 1'b1);
    localparam acc_t K_S9  = coef(MS9, 1'b0);
    localparam acc_t K_C0  = coef(MC0, 1'b0);
    localparam acc_t K_C2  = coef(MC2, 1'b1);
    localparam acc_t K_C4  = coef(MC4, 1'b0);
    localparam acc_t K_C6  = coef(MC6, 1'b1);
    localparam acc_t K_C8  = coef(MC8, 1'b0);
    localparam acc_t K_C10 = coef(MC10, 1'b1);

    // Per-cell stage shifts and the coefficient added after each product
    localparam int   SH_S_TAB [NCELL] = '{SHIFT + 6, SHIFT + 6, SHIFT + 4, SHIFT + 2, SHIFT};
    localparam int   SH_C_TAB [NCELL] = '{SHIFT + 6, SHIFT + 6, SHIFT + 5, SHIFT + 3, SHIFT + 1};
    localparam acc_t COEF_S_TAB [NCELL] = '{K_S7, K_S5, K_S3, K_S1, ACC_ZERO};
    localparam acc_t COEF_C_TAB [NCELL] = '{K_C8, K_C6, K_C4, K_C2, K_C0};

endpackage

// ===== hdl/fpsc_fold.sv =====
// Front end of the sine/cosine pipeline: two fold stages and the squaring stage.
// Depends on fpsc_pkg.

module fpsc_fold (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  fpsc_pkg::angle_t        i_angle,
    output logic                    o_valid,
    input  logic                    i_ready,
    output fpsc_pkg::carry_t        o_carry
);

    localparam int SQ_W = 2 * fpsc_pkg::ANGLE_W;

    logic                 a_vld_reg, a_vld_next;
    logic                 b_vld_reg, b_vld_next;
    logic                 c_vld_reg, c_vld_next;
    logic                 en_a, en_b, en_c;

    fpsc_pkg::fold_t      t0;
    fpsc_pkg::fold_t      a_t_reg, a_t_next;
    logic                 a_f_reg, a_f_next;
    fpsc_pkg::angle_t     b_t_reg, b_t_next;
    logic                 b_f_reg, b_f_next;
    logic                 b_neg;
    fpsc_pkg::fold_t      b_fold;
    logic signed [SQ_W-1:0] sq;
    fpsc_pkg::carry_t     c_carry_reg, c_carry_next;

    // A stage advances when it is empty or its successor advances
    assign en_c    = !c_vld_reg || i_ready;
    assign en_b    = !b_vld_reg || en_c;
    assign en_a    = !a_vld_reg || en_b;
    assign o_ready = en_a;

    assign a_vld_next = en_a ? i_valid   : a_vld_reg;
    assign b_vld_next = en_b ? a_vld_reg : b_vld_reg;
    assign c_vld_next = en_c ? b_vld_reg : c_vld_reg;

    // Fold about +pi/2
    always_comb begin
        t0       = fpsc_pkg::FOLD_W'(i_angle);
        a_f_next = (t0 > fpsc_pkg::HPI_FX);
        a_t_next = a_f_next ? (fpsc_pkg::PI_FX - t0) : t0;
    end

    // Fold about -pi/2; the result always fits the angle width
    always_comb begin
        b_neg    = (a_t_reg < fpsc_pkg::NEG_HPI_FX);
        b_fold   = b_neg ? (fpsc_pkg::NEG_PI_FX - a_t_reg) : a_t_reg;
        b_t_next = fpsc_pkg::ANGLE_W'(b_fold);
        b_f_next = a_f_reg || b_neg;
    end

    always_comb begin
        sq                  = SQ_W'(b_t_reg) * SQ_W'(b_t_reg);
        c_carry_next.x2     = fpsc_pkg::X2_W'(sq >>> fpsc_pkg::SHIFT);
        c_carry_next.t      = b_t_reg;
        c_carry_next.folded = b_f_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
            c_vld_reg <= c_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_t_reg <= a_t_next;
            a_f_reg <= a_f_next;
        end
        if (en_b) begin
            b_t_reg <= b_t_next;
            b_f_reg <= b_f_next;
        end
        if (en_c) begin
            c_carry_reg <= c_carry_next;
        end
    end

    assign o_valid = c_vld_reg;
    assign o_carry = c_carry_reg;

endmodule

// ===== hdl/fpsc_cell.sv =====
// One Horner cell: multiply both running sums, shift, add the next coefficients.
// Depends on fpsc_pkg.

module fpsc_cell #(
    parameter int             SH_S          = fpsc_pkg::SHIFT,
    parameter int             SH_C          = fpsc_pkg::SHIFT,
    parameter fpsc_pkg::acc_t COEF_S        = fpsc_pkg::ACC_ZERO,
    parameter fpsc_pkg::acc_t COEF_C        = fpsc_pkg::ACC_ZERO,
    parameter bit             SINE_BY_ANGLE = 1'b0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              i_valid,
    output logic              o_ready,
    input  fpsc_pkg::carry_t  i_carry,
    input  fpsc_pkg::acc_t    i_sum_s,
    input  fpsc_pkg::acc_t    i_sum_c,
    output logic              o_valid,
    input  logic              i_ready,
    output fpsc_pkg::carry_t  o_carry,
    output fpsc_pkg::acc_t    o_sum_s,
    output fpsc_pkg::acc_t    o_sum_c
);

    localparam int PROD_W = fpsc_pkg::X2_W + fpsc_pkg::ACC_W;

    typedef logic signed [PROD_W-1:0] prod_t;

    logic              mul_vld_reg, mul_vld_next;
    logic              sum_vld_reg, sum_vld_next;
    logic              en_mul, en_sum;
    fpsc_pkg::x2_t     op_s;
    prod_t             prod_s_reg, prod_s_next;
    prod_t             prod_c_reg, prod_c_next;
    fpsc_pkg::carry_t  mul_carry_reg;
    fpsc_pkg::acc_t    sum_s_reg, sum_s_next;
    fpsc_pkg::acc_t    sum_c_reg, sum_c_next;
    fpsc_pkg::carry_t  sum_carry_reg;

    assign en_sum  = !sum_vld_reg || i_ready;
    assign en_mul  = !mul_vld_reg || en_sum;
    assign o_ready = en_mul;

    assign mul_vld_next = en_mul ? i_valid     : mul_vld_reg;
    assign sum_vld_next = en_sum ? mul_vld_reg : sum_vld_reg;

    // The last sine term multiplies by the angle instead of its square
    assign op_s = SINE_BY_ANGLE ? fpsc_pkg::X2_W'(i_carry.t) : i_carry.x2;

    assign prod_s_next = PROD_W'(op_s) * PROD_W'(i_sum_s);
    assign prod_c_next = PROD_W'(i_carry.x2) * PROD_W'(i_sum_c);

    assign sum_s_next = COEF_S + fpsc_pkg::ACC_W'(prod_s_reg >>> SH_S);
    assign sum_c_next = COEF_C + fpsc_pkg::ACC_W'(prod_c_reg >>> SH_C);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
        end else begin
            mul_vld_reg <= mul_vld_next;
            sum_vld_reg <= sum_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            prod_s_reg    <= prod_s_next;
            prod_c_reg    <= prod_c_next;
            mul_carry_reg <= i_carry;
        end
        if (en_sum) begin
            sum_s_reg     <= sum_s_next;
            sum_c_reg     <= sum_c_next;
            sum_carry_reg <= mul_carry_reg;
        end
    end

    assign o_valid = sum_vld_reg;
    assign o_carry = sum_carry_reg;
    assign o_sum_s = sum_s_reg;
    assign o_sum_c = sum_c_reg;

endmodule

// ===== hdl/fixed_point_sine_cosine.sv =====
// Top level of the fixed-point sine/cosine block: fold front end, Horner cell chain, output.
// Depends on fpsc_pkg, fpsc_fold and fpsc_cell.
//
//   channel | ports                     | direction | payload
//   --------+---------------------------+-----------+-----------------------------
//   s_      | s_valid s_ready s_angle   | in        | angle, 28 b signed, Q.24
//   m_      | m_valid m_ready m_sine    | out       | sine, cosine, 26 b signed, Q.24
//           | m_cosine                  |           |
//
// One transaction per cycle sustained while m_ready stays high; the pipeline has three front-end stages
// (two folds, square), two stages in each of five Horner cells and one output register.
// Reset clears only the stage valid bits; no state carries between transactions.
// Each stage holds only while it is full and its successor holds, so bubbles close up
// and s_ready stays high under an output stall until the chain is full.

module fixed_point_sine_cosine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fpsc_pkg::angle_t s_angle,
    output logic             m_valid,
    input  logic             m_ready,
    output fpsc_pkg::out_t   m_sine,
    output fpsc_pkg::out_t   m_cosine
);

    localparam int NCELL = fpsc_pkg::NCELL;

    logic             vld [NCELL+1];
    logic             rdy [NCELL+1];
    fpsc_pkg::carry_t carry [NCELL+1];
    fpsc_pkg::acc_t   sum_s [NCELL+1];
    fpsc_pkg::acc_t   sum_c [NCELL+1];

    logic             m_valid_reg, m_valid_next;
    fpsc_pkg::out_t   m_sine_reg, m_sine_next;
    fpsc_pkg::out_t   m_cosine_reg, m_cosine_next;
    fpsc_pkg::acc_t   cos_fix;

    fpsc_fold u_fold (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (s_valid),
        .o_ready (s_ready),
        .i_angle (s_angle),
        .o_valid (vld[0]),
        .i_ready (rdy[0]),
        .o_carry (carry[0])
    );

    // Highest-order terms seed the chain
    assign sum_s[0] = fpsc_pkg::K_S9;
    assign sum_c[0] = fpsc_pkg::K_C10;

    genvar k;
    for (k = 0; k < NCELL; k++) begin : g_cell
        fpsc_cell #(
            .SH_S          (fpsc_pkg::SH_S_TAB[k]),
            .SH_C          (fpsc_pkg::SH_C_TAB[k]),
            .COEF_S        (fpsc_pkg::COEF_S_TAB[k]),
            .COEF_C        (fpsc_pkg::COEF_C_TAB[k]),
            .SINE_BY_ANGLE (k == NCELL - 1)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .i_valid (vld[k]),
            .o_ready (rdy[k]),
            .i_carry (carry[k]),
            .i_sum_s (sum_s[k]),
            .i_sum_c (sum_c[k]),
            .o_valid (vld[k+1]),
            .i_ready (rdy[k+1]),
            .o_carry (carry[k+1]),
            .o_sum_s (sum_s[k+1]),
            .o_sum_c (sum_c[k+1])
        );
    end

    assign rdy[NCELL] = !m_valid_reg || m_ready;

    // Negate the cosine when the angle was folded, keep the low bits
    always_comb begin
        cos_fix       = carry[NCELL].folded ? -sum_c[NCELL] : sum_c[NCELL];
        m_sine_next   = fpsc_pkg::OUT_W'(sum_s[NCELL]);
        m_cosine_next = fpsc_pkg::OUT_W'(cos_fix);
        m_valid_next  = rdy[NCELL] ? vld[NCELL] : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NCELL]) begin
            m_sine_reg   <= m_sine_next;
            m_cosine_reg <= m_cosine_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sine   = m_sine_reg;
    assign m_cosine = m_cosine_reg;

    // A free output end opens the whole chain back to the input
    a_ready_follows_sink: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    a_ready_when_empty_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low while output register empty");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high one cycle after reset");

    a_out_needs_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(vld[NCELL]))
        else $error("result appeared without a finished cell transaction");

endmodule
